@@ hdl/tns_pkg.sv @@
`timescale 1ns / 1ps

package tns_pkg;

  // Field widths are fixed by the stream format.
  localparam int ELEM_WIDTH    = 16;
  localparam int PROD_WIDTH    = 2 * ELEM_WIDTH;
  localparam int SCORE_WIDTH   = 48;
  localparam int INDEX_WIDTH   = 20;
  localparam int CFG_WIDTH     = 11;
  localparam int CFG_IDX_WIDTH = 2;
  localparam int CNT_WIDTH     = 10;
  localparam int CNT_LIMIT     = 1024;

  // Defaults for the top-level parameters.
  localparam int DEF_MAX_DIM   = 1024;
  localparam int DEF_ACC_WIDTH = 48;

  // Register reset values.
  localparam logic [CFG_WIDTH-1:0] RST_EMBEDDING_DIM   = 11'd64;
  localparam logic [CFG_WIDTH-1:0] RST_TOURNAMENT_SIZE = 11'd4;
  localparam logic [CFG_WIDTH-1:0] RST_SELECTED_COUNT  = 11'd16;

  typedef enum logic [CFG_IDX_WIDTH-1:0] {
    REG_EMBEDDING_DIM   = 2'd0,
    REG_TOURNAMENT_SIZE = 2'd1,
    REG_SELECTED_COUNT  = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic signed [ELEM_WIDTH-1:0] sel_query_elem;
    logic signed [ELEM_WIDTH-1:0] sel_neg_elem;
    logic signed [ELEM_WIDTH-1:0] score_query_elem;
    logic signed [ELEM_WIDTH-1:0] score_neg_elem;
  } in_word_t;

  typedef struct packed {
    logic signed [SCORE_WIDTH-1:0] selected_score;
    logic [INDEX_WIDTH-1:0]        neg_index;
    logic                          query_done;
  } out_word_t;

  // Effective (clamped) limits handed from the register file to the core.
  typedef struct packed {
    logic [CFG_WIDTH-1:0] dim;
    logic [CFG_WIDTH-1:0] ts;
    logic [CFG_WIDTH-1:0] sc;
  } limits_t;

  // Registered products, one pair per element.
  typedef struct packed {
    logic                         valid;
    logic signed [PROD_WIDTH-1:0] p_sel;
    logic signed [PROD_WIDTH-1:0] p_score;
  } prod_t;

  // Zero counts as one, anything above hi saturates to hi.
  function automatic logic [CFG_WIDTH-1:0] clamp_limit(input logic [CFG_WIDTH-1:0] v,
                                                       input logic [CFG_WIDTH-1:0] hi);
    logic [CFG_WIDTH-1:0] r;
    if (v == '0) begin
      r = CFG_WIDTH'(1);
    end else if (v > hi) begin
      r = hi;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

@@ hdl/tns_cfg.sv @@
`timescale 1ns / 1ps

module tns_cfg import tns_pkg::*; #(
  parameter int MAX_DIM = DEF_MAX_DIM
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_valid_i,
  input  logic [CFG_IDX_WIDTH-1:0] cfg_index_i,
  input  logic [CFG_WIDTH-1:0]     cfg_data_i,
  output logic                     cfg_ready_o,
  output limits_t                  limits_o
);

  localparam int DIM_LIMIT = (MAX_DIM < CNT_LIMIT) ? MAX_DIM : CNT_LIMIT;

  logic [CFG_WIDTH-1:0] dim_q, ts_q, sc_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dim_q <= RST_EMBEDDING_DIM;
      ts_q  <= RST_TOURNAMENT_SIZE;
      sc_q  <= RST_SELECTED_COUNT;
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_EMBEDDING_DIM:   dim_q <= cfg_data_i;
        REG_TOURNAMENT_SIZE: ts_q  <= cfg_data_i;
        REG_SELECTED_COUNT:  sc_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign limits_o.dim = clamp_limit(dim_q, CFG_WIDTH'(DIM_LIMIT));
  assign limits_o.ts  = clamp_limit(ts_q, CFG_WIDTH'(CNT_LIMIT));
  assign limits_o.sc  = clamp_limit(sc_q, CFG_WIDTH'(CNT_LIMIT));

endmodule

@@ hdl/tns_mul.sv @@
`timescale 1ns / 1ps

module tns_mul import tns_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  in_word_t in_word_i,
  output logic     in_stall_o,
  input  logic     out_free_i,
  output prod_t    prod_o
);

  logic                         valid_q;
  logic signed [PROD_WIDTH-1:0] p_sel_q, p_score_q;
  logic                         accept;

  // Hold the word only while the core cannot consume it.
  assign in_stall_o = valid_q && !out_free_i;
  assign accept     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= accept || (valid_q && !out_free_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      p_sel_q   <= PROD_WIDTH'(in_word_i.sel_query_elem) * PROD_WIDTH'(in_word_i.sel_neg_elem);
      p_score_q <= PROD_WIDTH'(in_word_i.score_query_elem)
                   * PROD_WIDTH'(in_word_i.score_neg_elem);
    end
  end

  assign prod_o.valid   = valid_q;
  assign prod_o.p_sel   = p_sel_q;
  assign prod_o.p_score = p_score_q;

endmodule

@@ hdl/tns_core.sv @@
`timescale 1ns / 1ps

module tns_core import tns_pkg::*; #(
  parameter int MAX_DIM   = DEF_MAX_DIM,
  parameter int ACC_WIDTH = DEF_ACC_WIDTH
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  prod_t     prod_i,
  input  limits_t   limits_i,
  input  logic      out_stall_i,
  output logic      out_free_o,
  output logic      out_valid_o,
  output out_word_t out_word_o
);

  localparam int DIM_LIMIT  = (MAX_DIM < CNT_LIMIT) ? MAX_DIM : CNT_LIMIT;
  localparam int ELEM_CNT_W = (DIM_LIMIT > 1) ? $clog2(DIM_LIMIT) : 1;
  localparam int CMP_W      = CFG_WIDTH + 1;
  localparam int IDX_FULL_W = CNT_WIDTH + CFG_WIDTH;

  logic [ELEM_CNT_W-1:0]       elem_q, elem_d;
  logic [CNT_WIDTH-1:0]        member_q, member_d;
  logic [CNT_WIDTH-1:0]        group_q, group_d;
  logic [CNT_WIDTH-1:0]        best_member_q, best_member_d;
  logic signed [ACC_WIDTH-1:0] sel_acc_q, sel_acc_d;
  logic signed [ACC_WIDTH-1:0] score_acc_q, score_acc_d;
  logic signed [ACC_WIDTH-1:0] best_sel_q, best_sel_d;
  logic signed [ACC_WIDTH-1:0] best_score_q, best_score_d;

  logic signed [ACC_WIDTH-1:0] sel_sum, score_sum;
  logic                        elem_last, member_last, group_last, take, emit, advance;
  logic [IDX_FULL_W-1:0]       idx_full;
  logic                        out_valid_q;
  out_word_t                   out_word_q;

  assign out_free_o = !out_valid_q || !out_stall_i;
  assign advance    = prod_i.valid && out_free_o;

  assign sel_sum   = sel_acc_q + ACC_WIDTH'(prod_i.p_sel);
  assign score_sum = score_acc_q + ACC_WIDTH'(prod_i.p_score);

  // "At least limit minus one" so a limit lowered mid-stream still completes.
  assign elem_last   = (CMP_W'(elem_q) + CMP_W'(1)) >= CMP_W'(limits_i.dim);
  assign member_last = (CMP_W'(member_q) + CMP_W'(1)) >= CMP_W'(limits_i.ts);
  assign group_last  = (CMP_W'(group_q) + CMP_W'(1)) >= CMP_W'(limits_i.sc);

  // First member always wins; later ones only on strictly greater.
  assign take = (member_q == '0) || (sel_sum > best_sel_q);
  assign emit = elem_last && member_last;

  always_comb begin
    elem_d        = elem_q;
    member_d      = member_q;
    group_d       = group_q;
    best_member_d = best_member_q;
    sel_acc_d     = sel_acc_q;
    score_acc_d   = score_acc_q;
    best_sel_d    = best_sel_q;
    best_score_d  = best_score_q;
    if (advance) begin
      if (!elem_last) begin
        elem_d      = elem_q + ELEM_CNT_W'(1);
        sel_acc_d   = sel_sum;
        score_acc_d = score_sum;
      end else begin
        elem_d      = '0;
        sel_acc_d   = '0;
        score_acc_d = '0;
        if (take) begin
          best_sel_d    = sel_sum;
          best_score_d  = score_sum;
          best_member_d = member_q;
        end
        if (!member_last) begin
          member_d = member_q + CNT_WIDTH'(1);
        end else begin
          member_d = '0;
          group_d  = group_last ? '0 : group_q + CNT_WIDTH'(1);
        end
      end
    end
  end

  assign idx_full = IDX_FULL_W'(group_q) * IDX_FULL_W'(limits_i.ts)
                    + IDX_FULL_W'(best_member_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      elem_q        <= '0;
      member_q      <= '0;
      group_q       <= '0;
      best_member_q <= '0;
      sel_acc_q     <= '0;
      score_acc_q   <= '0;
      best_sel_q    <= '0;
      best_score_q  <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      elem_q        <= elem_d;
      member_q      <= member_d;
      group_q       <= group_d;
      best_member_q <= best_member_d;
      sel_acc_q     <= sel_acc_d;
      score_acc_q   <= score_acc_d;
      best_sel_q    <= best_sel_d;
      best_score_q  <= best_score_d;
      if (out_free_o) begin
        out_valid_q <= advance && emit;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && emit) begin
      out_word_q.selected_score <= SCORE_WIDTH'(best_score_d);
      out_word_q.neg_index      <= idx_full[INDEX_WIDTH-1:0];
      out_word_q.query_done     <= group_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule

@@ hdl/tournament_negative_select.sv @@
`timescale 1ns / 1ps
// Path: an accepted word's result, if any, leaves via the product, then the result register.
// Throughput: one element word per cycle; a result register and the product
//   register sit between input and output, so input stalls only while a
//   finished result waits on a stalled output.
// Reset: rst_ni asynchronous, active low; clears all counters, accumulators and
//   valid flags and loads the register defaults (dim 64, group 4, count 16).
module tournament_negative_select import tns_pkg::*; #(
  parameter int MAX_DIM   = DEF_MAX_DIM,
  parameter int ACC_WIDTH = DEF_ACC_WIDTH
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // element word stream
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  in_word_t                 in_word_i,
  // selected negative stream
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output out_word_t                out_word_o,
  // register writes
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [CFG_IDX_WIDTH-1:0] cfg_index_i,
  input  logic [CFG_WIDTH-1:0]     cfg_data_i
);

  limits_t limits;
  prod_t   prod;
  logic    out_free;

  // Register file; limits leave here already clamped to their legal range.
  tns_cfg #(
    .MAX_DIM(MAX_DIM)
  ) u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .cfg_ready_o(cfg_ready_o),
    .limits_o   (limits)
  );

  // Input register: both 16x16 products are formed before the register, so
  // the accumulate/compare path downstream carries no multiplier.
  tns_mul u_mul (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_word_i (in_word_i),
    .in_stall_o(in_stall_o),
    .out_free_i(out_free),
    .prod_o    (prod)
  );

  // Accumulate, end-of-negative compare, group/query counters, result register.
  tns_core #(
    .MAX_DIM  (MAX_DIM),
    .ACC_WIDTH(ACC_WIDTH)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .prod_i     (prod),
    .limits_i   (limits),
    .out_stall_i(out_stall_i),
    .out_free_o (out_free),
    .out_valid_o(out_valid_o),
    .out_word_o (out_word_o)
  );

endmodule

@@ hdl/tns_checker.sv @@
`timescale 1ns / 1ps

module tns_checker import tns_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_stall_o,
  input logic      out_valid_o,
  input logic      out_stall_i
);

  // A result is held until taken.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // Input back-pressure only comes from a waiting, stalled result.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without output back-pressure");

  // A fresh result traces back to an accepted word via the product register.
  a_two_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && !in_stall_o, 2))
    else $error("result without matching accepted word");

endmodule

bind tournament_negative_select tns_checker u_tns_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_stall_o (in_stall_o),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i)
);

@@ dv/tournament_negative_select_tb.sv @@
`timescale 1ns / 1ps

module tournament_negative_select_tb import tns_pkg::*;;

  localparam int ACC_W     = DEF_ACC_WIDTH;
  localparam int DIM_HI    = (DEF_MAX_DIM < CNT_LIMIT) ? DEF_MAX_DIM : CNT_LIMIT;
  // Index 3 maps to no register; writes there must be ignored.
  localparam logic [CFG_IDX_WIDTH-1:0] REG_SPARE = 2'd3;
  localparam logic [CFG_WIDTH-1:0]     CFG_ALL_ONES = '1;
  // Results cross product and result registers; pad generously before a register write.
  localparam int SETTLE_CYCLES = 6;
  localparam int RANDOM_WORDS  = 1150;
  localparam int MIN_WINNERS   = 48;
  localparam int BIG_WORDS     = 1040;

  // ---------------------------------------------------------------------------
  // Predictor: tracks both dot products, the group's best candidate and the
  // counters, and queues the winner word expected at the end of every group.
  // ---------------------------------------------------------------------------
  class winner_board;
    logic [CFG_WIDTH-1:0] dim_reg, ts_reg, sc_reg;
    int unsigned elem_cnt, member_cnt, group_cnt, best_member;
    logic signed [ACC_W-1:0] sel_acc, score_acc, best_sel, best_score;
    out_word_t expected_winners[$];
    int unsigned bad_count;
    int unsigned winners_seen;

    function new();
      dim_reg      = RST_EMBEDDING_DIM;
      ts_reg       = RST_TOURNAMENT_SIZE;
      sc_reg       = RST_SELECTED_COUNT;
      elem_cnt     = 0;
      member_cnt   = 0;
      group_cnt    = 0;
      best_member  = 0;
      sel_acc      = '0;
      score_acc    = '0;
      best_sel     = '0;
      best_score   = '0;
      bad_count    = 0;
      winners_seen = 0;
    endfunction

    // 0 behaves as 1, anything past hi saturates
    function int unsigned eff_limit(logic [CFG_WIDTH-1:0] v, int unsigned hi);
      if (v == '0) return 1;
      if (v > hi) return hi;
      return 32'(v);
    endfunction

    function void write_reg(logic [CFG_IDX_WIDTH-1:0] idx, logic [CFG_WIDTH-1:0] v);
      case (idx)
        REG_EMBEDDING_DIM:   dim_reg = v;
        REG_TOURNAMENT_SIZE: ts_reg  = v;
        REG_SELECTED_COUNT:  sc_reg  = v;
        default: ;
      endcase
    endfunction

    function void note_elem(in_word_t w);
      logic signed [PROD_WIDTH-1:0] p_sel, p_score;
      int unsigned dim, ts, sc;
      out_word_t r;
      dim = eff_limit(dim_reg, DIM_HI);
      ts  = eff_limit(ts_reg, CNT_LIMIT);
      sc  = eff_limit(sc_reg, CNT_LIMIT);
      p_sel   = $signed(w.sel_query_elem) * $signed(w.sel_neg_elem);
      p_score = $signed(w.score_query_elem) * $signed(w.score_neg_elem);
      sel_acc   = sel_acc + {{(ACC_W-PROD_WIDTH){p_sel[PROD_WIDTH-1]}}, p_sel};
      score_acc = score_acc + {{(ACC_W-PROD_WIDTH){p_score[PROD_WIDTH-1]}}, p_score};

      // counters past a lowered limit finish on this word
      if (elem_cnt + 1 < dim) begin
        elem_cnt++;
        return;
      end
      elem_cnt = 0;
      // first member always taken; later ones only when strictly greater
      if (member_cnt == 0 || sel_acc > best_sel) begin
        best_sel    = sel_acc;
        best_score  = score_acc;
        best_member = member_cnt;
      end
      sel_acc   = '0;
      score_acc = '0;
      if (member_cnt + 1 < ts) begin
        member_cnt++;
        return;
      end
      member_cnt = 0;
      r.selected_score = SCORE_WIDTH'(best_score);
      r.neg_index      = INDEX_WIDTH'(group_cnt * ts + best_member);
      r.query_done     = (group_cnt + 1 >= sc);
      expected_winners.insert(expected_winners.size(), r);
      if (r.query_done) group_cnt = 0;
      else group_cnt++;
    endfunction

    function void check_winner(out_word_t got);
      out_word_t exp_w;
      winners_seen++;
      if (expected_winners.size() == 0) begin
        bad_count++;
        if (bad_count <= 10)
          $display("%0t: unexpected winner score=%0d index=%0d done=%0b", $time,
                   got.selected_score, got.neg_index, got.query_done);
        return;
      end
      exp_w = expected_winners.pop_front();
      if (got.selected_score !== exp_w.selected_score || got.neg_index !== exp_w.neg_index ||
          got.query_done !== exp_w.query_done) begin
        bad_count++;
        if (bad_count <= 10)
          $display("%0t: exp score=%0d idx=%0d done=%0b, got score=%0d idx=%0d done=%0b",
                   $time, exp_w.selected_score, exp_w.neg_index, exp_w.query_done,
                   got.selected_score, got.neg_index, got.query_done);
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_n = 1'b0;

  logic                     in_valid  = 1'b0;
  in_word_t                 in_word   = '0;
  logic                     in_stall_o;
  logic                     out_valid_o;
  logic                     out_stall = 1'b0;
  out_word_t                out_word_o;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready_o;
  logic [CFG_IDX_WIDTH-1:0] cfg_index = '0;
  logic [CFG_WIDTH-1:0]     cfg_data  = '0;

  // idle bursts on both sides are enabled per phase
  bit idle_on = 1'b0;

  winner_board sb;

  tournament_negative_select i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall),
    .out_word_o  (out_word_o),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #10_000_000;
    $display("tournament_negative_select test failed");
    $finish;
  end

  // Output side: random stall bursts, changed only at the falling edge.
  initial begin : out_backpressure
    int unsigned hold;
    hold = 0;
    forever begin
      @(negedge clk_i);
      if (!idle_on) hold = 0;
      if (hold != 0) begin
        hold--;
        out_stall <= 1'b1;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        hold = $urandom_range(1, 18) - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Winner words are taken at the rising edge when valid and not stalled.
  always @(posedge clk_i) begin
    if (rst_n && out_valid_o && !out_stall) sb.check_winner(out_word_o);
  end

  // Element word: full range, extremes, or tiny values so that dots tie often.
  function automatic logic [ELEM_WIDTH-1:0] pick_elem();
    int unsigned r;
    int s;
    r = $urandom_range(0, 7);
    case (r)
      0: begin
        case ($urandom_range(0, 3))
          0: return 16'h8000;
          1: return 16'h7FFF;
          2: return 16'h0000;
          default: return 16'hFFFF;
        endcase
      end
      1, 2, 3: begin
        s = int'($urandom_range(0, 6)) - 3;
        return s[ELEM_WIDTH-1:0];
      end
      default: return ELEM_WIDTH'($urandom);
    endcase
  endfunction

  function automatic in_word_t random_word();
    in_word_t w;
    w.sel_query_elem   = pick_elem();
    w.sel_neg_elem     = pick_elem();
    w.score_query_elem = pick_elem();
    w.score_neg_elem   = pick_elem();
    return w;
  endfunction

  function automatic in_word_t mk(logic [ELEM_WIDTH-1:0] sq, logic [ELEM_WIDTH-1:0] sn,
                                  logic [ELEM_WIDTH-1:0] cq, logic [ELEM_WIDTH-1:0] cn);
    in_word_t w;
    w.sel_query_elem   = sq;
    w.sel_neg_elem     = sn;
    w.score_query_elem = cq;
    w.score_neg_elem   = cn;
    return w;
  endfunction

  // Valid stays high across back-to-back words; it only drops for a gap.
  task automatic send_word(input in_word_t w);
    @(negedge clk_i);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(negedge clk_i);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_elem(w);
  endtask

  task automatic hold_input();
    @(negedge clk_i);
    in_valid <= 1'b0;
  endtask

  // Wait out every queued winner, then the pipeline, so the block is idle.
  task automatic settle_all();
    hold_input();
    while (sb.expected_winners.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_WIDTH-1:0] idx,
                           input logic [CFG_WIDTH-1:0] data);
    @(negedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    sb.write_reg(idx, data);
    @(negedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  task automatic load_limits(input logic [CFG_WIDTH-1:0] dim, input logic [CFG_WIDTH-1:0] ts,
                             input logic [CFG_WIDTH-1:0] sc);
    write_reg(REG_EMBEDDING_DIM, dim);
    write_reg(REG_TOURNAMENT_SIZE, ts);
    write_reg(REG_SELECTED_COUNT, sc);
    if ($urandom_range(0, 3) == 0) write_reg(REG_SPARE, CFG_WIDTH'($urandom));
  endtask

  // One phase of random words; sometimes the sender drains midway.
  task automatic run_phase(input int unsigned n_words);
    bit drain_mid;
    drain_mid = ($urandom_range(0, 3) == 0);
    for (int unsigned k = 0; k < n_words; k++) begin
      if (drain_mid && k == n_words / 2) settle_all();
      send_word(random_word());
    end
    settle_all();
  endtask

  initial begin : stimulus
    int unsigned phase;
    int unsigned random_words;
    logic [CFG_WIDTH-1:0] dim, ts, sc;
    int unsigned n;
    sb = new();
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Directed: one element per negative, one negative per group -> every word
    // yields a winner; covers product extremes and query_done every third.
    load_limits(11'd1, 11'd1, 11'd3);
    send_word(mk(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF));
    send_word(mk(16'h8000, 16'h8000, 16'h8000, 16'h8000));
    send_word(mk(16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000));
    send_word(mk(16'h0000, 16'h0000, 16'h0000, 16'h0000));
    send_word(mk(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0001));
    send_word(mk(16'h5555, 16'hAAAA, 16'hAAAA, 16'h5555));
    settle_all();

    // Directed: two elements, three members. First group ties three ways (the
    // first must win); second group has a strict improvement, then a tie.
    load_limits(11'd2, 11'd3, 11'd2);
    send_word(mk(16'd1, 16'd1, 16'd5, 16'd5));
    send_word(mk(16'd1, 16'd1, 16'd7, 16'd0));
    send_word(mk(16'd2, 16'd1, -16'sd3, 16'd4));
    send_word(mk(16'd0, 16'd9, 16'd1, 16'd1));
    send_word(mk(-16'sd1, -16'sd2, 16'd100, 16'd100));
    send_word(mk(16'd0, 16'd0, 16'd0, 16'd0));
    send_word(mk(-16'sd5, 16'd1, 16'd2, 16'd2));
    send_word(mk(16'd0, 16'd0, 16'd0, 16'd0));
    send_word(mk(-16'sd3, 16'd1, 16'd3, 16'd3));
    send_word(mk(16'd0, 16'd5, 16'd0, 16'd0));
    send_word(mk(16'd3, -16'sd1, 16'd4, 16'd4));
    send_word(mk(16'd0, 16'd0, 16'd0, 16'd0));
    settle_all();

    // Random phases. Counters carry over between phases, so lowered limits
    // hit counters already past them. One phase runs the saturated group count.
    phase = 0;
    random_words = 0;
    while (random_words < RANDOM_WORDS || sb.winners_seen < MIN_WINNERS || phase < 5) begin
      idle_on = ($urandom_range(0, 3) != 0);
      case (phase)
        2: begin
          // 2047 groups saturate at 1024: query_done only on group 1023
          load_limits(11'd1, 11'd1, CFG_ALL_ONES);
          run_phase(BIG_WORDS);
          random_words += BIG_WORDS;
        end
        default: begin
          dim = ($urandom_range(0, 7) == 0) ? 11'd0 : CFG_WIDTH'($urandom_range(1, 6));
          ts  = ($urandom_range(0, 7) == 0) ? 11'd0 : CFG_WIDTH'($urandom_range(1, 5));
          case ($urandom_range(0, 9))
            0:       sc = 11'd0;
            1:       sc = CFG_ALL_ONES;
            default: sc = CFG_WIDTH'($urandom_range(1, 8));
          endcase
          load_limits(dim, ts, sc);
          n = $urandom_range(30, 90);
          run_phase(n);
          random_words += n;
        end
      endcase
      phase++;
    end

    // Closing stretch with no idling on either side.
    idle_on = 1'b0;
    load_limits(CFG_WIDTH'($urandom_range(1, 3)), CFG_WIDTH'($urandom_range(1, 4)),
                CFG_WIDTH'($urandom_range(1, 5)));
    run_phase(100);

    if (sb.bad_count == 0 && sb.expected_winners.size() == 0) begin
      $display("tournament_negative_select test passed");
    end else begin
      $display("tournament_negative_select test failed");
    end
    $finish;
  end

endmodule

@@ tournament_negative_select.f @@
hdl/tns_pkg.sv
hdl/tns_cfg.sv
hdl/tns_mul.sv
hdl/tns_core.sv
hdl/tournament_negative_select.sv
hdl/tns_checker.sv
dv/tournament_negative_select_tb.sv
